// ===== design/tscp_pkg.sv =====
// ----------------------------------------------------------------------------
// tscp_pkg
// Types and constants shared by the tone-score command parser.
// ----------------------------------------------------------------------------
package tscp_pkg;

   localparam int NUM_GENERATORS = 6;
   localparam logic [4:0] GEN_LIMIT = 5'(NUM_GENERATORS);

   localparam logic [7:0] HDR_BYTE0   = 8'h50;
   localparam logic [7:0] HDR_BYTE1   = 8'h74;
   localparam logic [7:0] HDR_MIN_LEN = 8'd3;

   localparam logic [3:0] OP_NOTE_OFF = 4'h8;
   localparam logic [3:0] OP_NOTE_ON  = 4'h9;
   localparam logic [3:0] OP_INSTR    = 4'hC;
   localparam logic [3:0] OP_END_E    = 4'hE;
   localparam logic [3:0] OP_END_F    = 4'hF;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_HLEN  = 3'd2,
      PH_SKIP  = 3'd3,
      PH_CMD   = 3'd4,
      PH_DELAY = 3'd5,
      PH_ARG   = 3'd6,
      PH_DONE  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_DELAY    = 3'd0,
      EV_NOTE_ON  = 3'd1,
      EV_NOTE_OFF = 3'd2,
      EV_END      = 3'd3,
      EV_BAD_HDR  = 3'd4,
      EV_BAD_BYTE = 3'd5,
      EV_STOPPED  = 3'd6,
      EV_RAN_OUT  = 3'd7
   } event_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  header_remaining;
      logic [7:0]  held_command_byte;
   } state_type;

   typedef struct packed {
      logic        valid;
      event_type   event_res;
      logic [3:0]  generator;
      logic [7:0]  note;
      logic [14:0] delay_ms;
   } result_type;

endpackage

// ===== design/tscp_decode.sv =====
// ----------------------------------------------------------------------------
// tscp_decode
// Decodes one score byte against the parser state: next state and event.
// ----------------------------------------------------------------------------
module tscp_decode (
   input  tscp_pkg::state_type  state,
   input  logic                 cmd,
   input  logic [7:0]           score_byte,
   input  logic                 last_byte,
   output tscp_pkg::state_type  next_state,
   output tscp_pkg::result_type result
);

   logic [3:0]          hi;
   logic [3:0]          lo;
   logic [3:0]          held_hi;
   logic                gen_bad;
   tscp_pkg::phase_type step_phase;
   logic [7:0]          step_remaining;
   logic [7:0]          skip_remaining;

   assign hi             = score_byte[7:4];
   assign lo             = score_byte[3:0];
   assign held_hi        = state.held_command_byte[7:4];
   assign gen_bad        = {1'b0, lo} >= tscp_pkg::GEN_LIMIT;
   assign skip_remaining = (state.header_remaining != 8'd0) ?
                           state.header_remaining - 8'd1 : 8'd0;

   always_comb begin
      step_phase     = state.phase;
      step_remaining = state.header_remaining;
      next_state     = state;
      if (state.phase != tscp_pkg::PH_DONE) begin
         if (cmd) begin
            step_phase = tscp_pkg::PH_DONE;
         end else begin
            case (state.phase)
               tscp_pkg::PH_HDR0: begin
                  step_phase = (score_byte == tscp_pkg::HDR_BYTE0) ?
                               tscp_pkg::PH_HDR1 : tscp_pkg::PH_DONE;
               end
               tscp_pkg::PH_HDR1: begin
                  step_phase = (score_byte == tscp_pkg::HDR_BYTE1) ?
                               tscp_pkg::PH_HLEN : tscp_pkg::PH_DONE;
               end
               tscp_pkg::PH_HLEN: begin
                  step_remaining = (score_byte < tscp_pkg::HDR_MIN_LEN) ?
                                   8'd0 : score_byte - tscp_pkg::HDR_MIN_LEN;
                  step_phase     = (step_remaining != 8'd0) ?
                                   tscp_pkg::PH_SKIP : tscp_pkg::PH_CMD;
               end
               tscp_pkg::PH_SKIP: begin
                  step_remaining = skip_remaining;
                  if (skip_remaining == 8'd0) begin
                     step_phase = tscp_pkg::PH_CMD;
                  end
               end
               tscp_pkg::PH_DELAY: step_phase = tscp_pkg::PH_CMD;
               tscp_pkg::PH_ARG:   step_phase = tscp_pkg::PH_CMD;
               tscp_pkg::PH_CMD: begin
                  next_state.held_command_byte = score_byte;
                  if (!score_byte[7]) begin
                     step_phase = tscp_pkg::PH_DELAY;
                  end else begin
                     case (hi)
                        tscp_pkg::OP_END_E, tscp_pkg::OP_END_F:
                           step_phase = tscp_pkg::PH_DONE;
                        tscp_pkg::OP_NOTE_OFF:
                           step_phase = gen_bad ? tscp_pkg::PH_DONE : tscp_pkg::PH_CMD;
                        tscp_pkg::OP_NOTE_ON:
                           step_phase = gen_bad ? tscp_pkg::PH_DONE : tscp_pkg::PH_ARG;
                        tscp_pkg::OP_INSTR:
                           step_phase = tscp_pkg::PH_ARG;
                        default:
                           step_phase = tscp_pkg::PH_DONE;
                     endcase
                  end
               end
               default: step_phase = state.phase;
            endcase
         end
      end
      next_state.phase            = step_phase;
      next_state.header_remaining = step_remaining;
      if (last_byte) begin
         next_state.phase             = tscp_pkg::PH_HDR0;
         next_state.header_remaining  = 8'd0;
         next_state.held_command_byte = 8'd0;
      end
   end

   always_comb begin
      result           = '0;
      result.event_res = tscp_pkg::EV_DELAY;
      if (state.phase != tscp_pkg::PH_DONE) begin
         if (cmd) begin
            result.valid     = 1'b1;
            result.event_res = tscp_pkg::EV_STOPPED;
         end else begin
            case (state.phase)
               tscp_pkg::PH_HDR0: begin
                  result.valid     = score_byte != tscp_pkg::HDR_BYTE0;
                  result.event_res = tscp_pkg::EV_BAD_HDR;
               end
               tscp_pkg::PH_HDR1: begin
                  result.valid     = score_byte != tscp_pkg::HDR_BYTE1;
                  result.event_res = tscp_pkg::EV_BAD_HDR;
               end
               tscp_pkg::PH_DELAY: begin
                  result.valid     = 1'b1;
                  result.event_res = tscp_pkg::EV_DELAY;
                  result.delay_ms  = {state.held_command_byte[6:0], score_byte};
               end
               tscp_pkg::PH_ARG: begin
                  if (held_hi == tscp_pkg::OP_NOTE_ON) begin
                     result.valid     = 1'b1;
                     result.event_res = tscp_pkg::EV_NOTE_ON;
                     result.generator = state.held_command_byte[3:0];
                     result.note      = score_byte;
                  end
               end
               tscp_pkg::PH_CMD: begin
                  if (score_byte[7]) begin
                     case (hi)
                        tscp_pkg::OP_END_E, tscp_pkg::OP_END_F: begin
                           result.valid     = 1'b1;
                           result.event_res = tscp_pkg::EV_END;
                        end
                        tscp_pkg::OP_NOTE_OFF: begin
                           result.valid     = 1'b1;
                           result.event_res = gen_bad ? tscp_pkg::EV_BAD_BYTE :
                                              tscp_pkg::EV_NOTE_OFF;
                           result.generator = gen_bad ? 4'd0 : lo;
                        end
                        tscp_pkg::OP_NOTE_ON: begin
                           result.valid     = gen_bad;
                           result.event_res = tscp_pkg::EV_BAD_BYTE;
                        end
                        tscp_pkg::OP_INSTR: result.valid = 1'b0;
                        default: begin
                           result.valid     = 1'b1;
                           result.event_res = tscp_pkg::EV_BAD_BYTE;
                        end
                     endcase
                  end
               end
               default: result.valid = 1'b0;
            endcase
         end
         if (last_byte && step_phase != tscp_pkg::PH_DONE) begin
            result           = '0;
            result.valid     = 1'b1;
            result.event_res = tscp_pkg::EV_RAN_OUT;
         end
      end
   end

endmodule

// ===== design/tone_score_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// tone_score_command_parser_top
// Tone-score byte stream parser reporting delay, note and status events.
// ----------------------------------------------------------------------------
// One score byte (or stop) is taken per cycle while req_stall is low and is
// decoded in a single pass between the parser state registers and the result
// register, so each transfer produces at most one registered event.
// A two-entry output (result register plus skid register) keeps the input
// open while one event waits on rsp_stall; req_stall rises only when both
// entries are full.
module tone_score_command_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_score_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_generator,
   output logic [7:0]  rsp_note,
   output logic [14:0] rsp_delay_ms
);

   tscp_pkg::state_type  state_ff;
   tscp_pkg::state_type  state_in;
   tscp_pkg::result_type dec_result;
   tscp_pkg::result_type out_ff;
   tscp_pkg::result_type out_in;
   tscp_pkg::result_type skid_ff;
   tscp_pkg::result_type skid_in;
   logic                 in_fire;
   logic                 out_free;
   logic                 new_result;

   tscp_decode u_decode (
      .state      (state_ff),
      .cmd        (req_cmd),
      .score_byte (req_score_byte),
      .last_byte  (req_last_byte),
      .next_state (state_in),
      .result     (dec_result)
   );

   assign req_stall  = skid_ff.valid;
   assign in_fire    = req_valid && !req_stall;
   assign out_free   = !out_ff.valid || !rsp_stall;
   assign new_result = in_fire && dec_result.valid;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (out_free) begin
         if (skid_ff.valid) begin
            out_in        = skid_ff;
            skid_in       = dec_result;
            skid_in.valid = new_result;
         end else begin
            out_in       = dec_result;
            out_in.valid = new_result;
         end
      end else if (new_result) begin
         skid_in = dec_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase             <= tscp_pkg::PH_HDR0;
         state_ff.header_remaining  <= 8'd0;
         state_ff.held_command_byte <= 8'd0;
         out_ff.valid               <= 1'b0;
         skid_ff.valid              <= 1'b0;
      end else begin
         if (in_fire) begin
            state_ff <= state_in;
         end
         out_ff.valid  <= out_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
      out_ff.event_res  <= out_in.event_res;
      out_ff.generator  <= out_in.generator;
      out_ff.note       <= out_in.note;
      out_ff.delay_ms   <= out_in.delay_ms;
      skid_ff.event_res <= skid_in.event_res;
      skid_ff.generator <= skid_in.generator;
      skid_ff.note      <= skid_in.note;
      skid_ff.delay_ms  <= skid_in.delay_ms;
   end

   assign rsp_valid     = out_ff.valid;
   assign rsp_event_res = out_ff.event_res;
   assign rsp_generator = out_ff.generator;
   assign rsp_note      = out_ff.note;
   assign rsp_delay_ms  = out_ff.delay_ms;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tone-score command parser.
// ----------------------------------------------------------------------------
// Scores are fed one byte (or stop) per transfer. A bench-side copy of the
// parser state computes the event each accepted transfer should cause, and
// every result transfer is compared against the oldest pending event. The
// stimulus is a directed set of scores followed by random scores: mostly
// well-formed headers and command streams, plus noise, broken headers, stops
// and cut-off scores. Both sides idle in random bursts, the result side also
// holds off once for a long stretch to fill the block, and the last part of
// the run uses full-rate transfers.
// ----------------------------------------------------------------------------
module tb_top;
   import tscp_pkg::*;

   localparam logic       CMD_BYTE       = 1'b0;
   localparam logic       CMD_STOP       = 1'b1;
   localparam logic [3:0] OP_UNUSED_A    = 4'hA;
   localparam logic [3:0] OP_UNUSED_B    = 4'hB;
   localparam logic [3:0] OP_UNUSED_D    = 4'hD;
   localparam int         LONG_HOLD      = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 10;
   localparam int         MAX_REPORTS    = 10;

   typedef struct packed {
      event_type   kind;
      logic [3:0]  gen;
      logic [7:0]  note;
      logic [14:0] delay;
   } tone_event_t;

   typedef struct packed {
      logic       cmd;
      logic [7:0] value;
   } score_item_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [7:0]  req_score_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [3:0]  rsp_generator;
   logic [7:0]  rsp_note;
   logic [14:0] rsp_delay_ms;

   // parser state as seen by the bench
   phase_type   parse_at  = PH_HDR0;
   logic [7:0]  skip_left = '0;
   logic [7:0]  held_byte = '0;

   tone_event_t expected_events[$];
   score_item_t score_items[$];
   tone_event_t front_event;

   bit idle_on = 1'b1;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int items_sent = 0;
   int live_items = 0;
   int events_checked = 0;
   int kind_seen[8];

   tone_score_command_parser_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_score_byte (req_score_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_res  (rsp_event_res),
      .rsp_generator  (rsp_generator),
      .rsp_note       (rsp_note),
      .rsp_delay_ms   (rsp_delay_ms)
   );

   always #5 clock = ~clock;

   // Advance the parser by one transfer; returns 1 when an event is due.
   function automatic bit predict_event(input logic cmd, input logic [7:0] value,
                                        input logic last, output tone_event_t ev);
      bit         fired;
      logic [3:0] op;
      logic [3:0] chan;
      fired = 1'b0;
      ev    = '0;
      op    = value[7:4];
      chan  = value[3:0];
      if (parse_at != PH_DONE) begin
         if (cmd == CMD_STOP) begin
            parse_at = PH_DONE;
            fired    = 1'b1;
            ev.kind  = EV_STOPPED;
         end else begin
            case (parse_at)
               PH_HDR0: begin
                  if (value != HDR_BYTE0) begin
                     parse_at = PH_DONE;
                     fired    = 1'b1;
                     ev.kind  = EV_BAD_HDR;
                  end else begin
                     parse_at = PH_HDR1;
                  end
               end
               PH_HDR1: begin
                  if (value != HDR_BYTE1) begin
                     parse_at = PH_DONE;
                     fired    = 1'b1;
                     ev.kind  = EV_BAD_HDR;
                  end else begin
                     parse_at = PH_HLEN;
                  end
               end
               PH_HLEN: begin
                  skip_left = (value < HDR_MIN_LEN) ? 8'd0 : value - HDR_MIN_LEN;
                  parse_at  = (skip_left != 0) ? PH_SKIP : PH_CMD;
               end
               PH_SKIP: begin
                  if (skip_left != 0) skip_left = skip_left - 8'd1;
                  if (skip_left == 0) parse_at = PH_CMD;
               end
               PH_DELAY: begin
                  parse_at = PH_CMD;
                  fired    = 1'b1;
                  ev.kind  = EV_DELAY;
                  ev.delay = {held_byte[6:0], value};
               end
               PH_ARG: begin
                  parse_at = PH_CMD;
                  if (held_byte[7:4] == OP_NOTE_ON) begin
                     fired   = 1'b1;
                     ev.kind = EV_NOTE_ON;
                     ev.gen  = held_byte[3:0];
                     ev.note = value;
                  end
               end
               PH_CMD: begin
                  held_byte = value;
                  if (!value[7]) begin
                     parse_at = PH_DELAY;
                  end else if (op == OP_END_E || op == OP_END_F) begin
                     parse_at = PH_DONE;
                     fired    = 1'b1;
                     ev.kind  = EV_END;
                  end else if (op == OP_NOTE_OFF || op == OP_NOTE_ON) begin
                     if ({1'b0, chan} >= GEN_LIMIT) begin
                        parse_at = PH_DONE;
                        fired    = 1'b1;
                        ev.kind  = EV_BAD_BYTE;
                     end else if (op == OP_NOTE_OFF) begin
                        fired   = 1'b1;
                        ev.kind = EV_NOTE_OFF;
                        ev.gen  = chan;
                     end else begin
                        parse_at = PH_ARG;
                     end
                  end else if (op == OP_INSTR) begin
                     parse_at = PH_ARG;
                  end else begin
                     parse_at = PH_DONE;
                     fired    = 1'b1;
                     ev.kind  = EV_BAD_BYTE;
                  end
               end
               default: ;
            endcase
         end
         if (last && parse_at != PH_DONE) begin
            fired   = 1'b1;
            ev      = '0;
            ev.kind = EV_RAN_OUT;
         end
      end
      if (last) begin
         parse_at  = PH_HDR0;
         skip_left = '0;
         held_byte = '0;
      end
      return fired;
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] value, input logic last);
      tone_event_t ev;
      int          gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid      <= 1'b0;
         req_cmd        <= 1'($urandom);
         req_score_byte <= 8'($urandom);
         req_last_byte  <= 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_score_byte <= value;
      req_last_byte  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (parse_at != PH_DONE) live_items++;
      if (predict_event(cmd, value, last, ev)) expected_events.push_back(ev);
   endtask

   task automatic play_score();
      foreach (score_items[i])
         send_item(score_items[i].cmd, score_items[i].value, i == score_items.size() - 1);
   endtask

   task automatic build_random_score();
      int         len;
      int         pick;
      int         keep;
      logic [3:0] chan;
      logic [3:0] odd_op;
      score_items.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12))
            score_items.push_back({1'($urandom_range(0, 15) == 0), 8'($urandom)});
         return;
      end
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
      score_items.push_back({CMD_BYTE, HDR_BYTE0});
      score_items.push_back({CMD_BYTE, HDR_BYTE1});
      score_items.push_back({CMD_BYTE, 8'(len)});
      for (int i = 3; i < len; i++) score_items.push_back({CMD_BYTE, 8'($urandom)});
      if ($urandom_range(0, 24) == 0) score_items[$urandom_range(0, 1)].value = 8'($urandom);
      repeat ($urandom_range(0, 16)) begin
         chan = ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                            : 4'($urandom_range(0, NUM_GENERATORS - 1));
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            score_items.push_back({CMD_BYTE, 8'($urandom_range(0, 127))});
            score_items.push_back({CMD_BYTE, 8'($urandom)});
         end else if (pick < 60) begin
            score_items.push_back({CMD_BYTE, OP_NOTE_ON, chan});
            score_items.push_back({CMD_BYTE, 8'($urandom)});
         end else if (pick < 80) begin
            score_items.push_back({CMD_BYTE, OP_NOTE_OFF, chan});
         end else if (pick < 92) begin
            score_items.push_back({CMD_BYTE, OP_INSTR, chan});
            score_items.push_back({CMD_BYTE, 8'($urandom)});
         end else begin
            case ($urandom_range(0, 2))
               0:       odd_op = OP_UNUSED_A;
               1:       odd_op = OP_UNUSED_B;
               default: odd_op = OP_UNUSED_D;
            endcase
            score_items.push_back({CMD_BYTE, odd_op, chan});
         end
         if ($urandom_range(0, 59) == 0) score_items.push_back({CMD_STOP, 8'($urandom)});
      end
      pick = $urandom_range(0, 19);
      if (pick < 12)
         score_items.push_back({CMD_BYTE, ($urandom_range(0, 1) ? OP_END_E : OP_END_F),
                                4'($urandom)});
      else if (pick < 15)
         score_items.push_back({CMD_STOP, 8'($urandom)});
      repeat ($urandom_range(0, 2)) score_items.push_back({CMD_BYTE, 8'($urandom)});
      // cut the score short now and then
      if ($urandom_range(0, 14) == 0) begin
         keep = $urandom_range(1, score_items.size());
         while (score_items.size() > keep) void'(score_items.pop_back());
      end
   endtask

   task automatic test_directed_scores();
      idle_on = 1'b1;
      // every command, short header length, extreme delay and note
      send_item(CMD_BYTE, HDR_BYTE0, 1'b0);
      send_item(CMD_BYTE, HDR_BYTE1, 1'b0);
      send_item(CMD_BYTE, 8'h02, 1'b0);
      send_item(CMD_BYTE, 8'h7F, 1'b0);
      send_item(CMD_BYTE, 8'hFF, 1'b0);
      send_item(CMD_BYTE, {OP_NOTE_ON, 4'(NUM_GENERATORS - 1)}, 1'b0);
      send_item(CMD_BYTE, 8'hFF, 1'b0);
      send_item(CMD_BYTE, {OP_NOTE_OFF, 4'h0}, 1'b0);
      send_item(CMD_BYTE, {OP_INSTR, 4'hF}, 1'b0);
      send_item(CMD_BYTE, 8'h00, 1'b0);
      send_item(CMD_BYTE, {OP_END_F, 4'h0}, 1'b1);
      // wrong first header byte
      send_item(CMD_BYTE, HDR_BYTE1, 1'b1);
      // skipped header bytes, then an unknown command
      send_item(CMD_BYTE, HDR_BYTE0, 1'b0);
      send_item(CMD_BYTE, HDR_BYTE1, 1'b0);
      send_item(CMD_BYTE, 8'h05, 1'b0);
      send_item(CMD_BYTE, 8'h11, 1'b0);
      send_item(CMD_BYTE, 8'h22, 1'b0);
      send_item(CMD_BYTE, {OP_UNUSED_A, 4'h5}, 1'b1);
      // wrong second header byte, then stop in a finished score
      send_item(CMD_BYTE, HDR_BYTE0, 1'b0);
      send_item(CMD_BYTE, HDR_BYTE0, 1'b0);
      send_item(CMD_STOP, 8'hFF, 1'b1);
      // generator out of range
      send_item(CMD_BYTE, HDR_BYTE0, 1'b0);
      send_item(CMD_BYTE, HDR_BYTE1, 1'b0);
      send_item(CMD_BYTE, HDR_MIN_LEN, 1'b0);
      send_item(CMD_BYTE, {OP_NOTE_OFF, 4'(NUM_GENERATORS)}, 1'b1);
      // stop in a live score
      send_item(CMD_STOP, 8'h00, 1'b1);
      // score cut after the first byte of a note on
      send_item(CMD_BYTE, HDR_BYTE0, 1'b0);
      send_item(CMD_BYTE, HDR_BYTE1, 1'b0);
      send_item(CMD_BYTE, HDR_MIN_LEN, 1'b0);
      send_item(CMD_BYTE, {OP_NOTE_ON, 4'h4}, 1'b1);
   endtask

   task automatic test_random_scores();
      int stop_at;
      stop_at = items_sent + 1380;
      while (items_sent < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         build_random_score();
         play_score();
      end
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_requests++;
      score_items.delete();
      score_items.push_back({CMD_BYTE, HDR_BYTE0});
      score_items.push_back({CMD_BYTE, HDR_BYTE1});
      score_items.push_back({CMD_BYTE, HDR_MIN_LEN});
      repeat (30)
         score_items.push_back({CMD_BYTE, OP_NOTE_OFF,
                                4'($urandom_range(0, NUM_GENERATORS - 1))});
      score_items.push_back({CMD_BYTE, OP_END_E, 4'h0});
      play_score();
   endtask

   task automatic test_full_rate_scores();
      int stop_at;
      idle_on = 1'b0;
      stop_at = items_sent + 300;
      while (items_sent < stop_at) begin
         build_random_score();
         play_score();
      end
   endtask

   task automatic report_mismatch(input string what, input tone_event_t want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: expected ev %0d gen %0d note %0d delay %0d, got ev %0d gen %0d %s",
                  $realtime, what, want.kind, want.gen, want.note, want.delay,
                  rsp_event_res, rsp_generator,
                  $sformatf("note %0d delay %0d", rsp_note, rsp_delay_ms));
   endtask

   // result side: random stall bursts, one long hold-off per request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_started != hold_requests) begin
         holds_started++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected result", '0);
         end else begin
            front_event = expected_events.pop_front();
            events_checked++;
            kind_seen[front_event.kind]++;
            if (rsp_event_res !== front_event.kind || rsp_generator !== front_event.gen ||
                rsp_note !== front_event.note || rsp_delay_ms !== front_event.delay)
               report_mismatch("wrong result", front_event);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d events pending",
                  WATCHDOG_LIMIT, expected_events.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_BYTE;
      req_score_byte = '0;
      req_last_byte  = 1'b0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_scores();
      test_random_scores();
      test_output_backpressure();
      test_full_rate_scores();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d transfers in (%0d into live scores), %0d events checked, %0d bad",
               items_sent, live_items, events_checked, mismatches);
      $display("Events: delay %0d, on %0d, off %0d, end %0d, hdr %0d, byte %0d, stop %0d, out %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
